// ----- hdl/ntg_pkg.sv -----
`default_nettype none
package ntg_pkg;

  // Mesh and address geometry
  localparam int MAX_NODES         = 256;
  localparam int BLOCK_OFFSET_BITS = 6;
  localparam int NODE_LOG2_FLOOR   = $clog2(MAX_NODES + 1) - 1;
  localparam int RADIX_LOG2_CAP    = (NODE_LOG2_FLOOR / 2 > 4) ? 4 : NODE_LOG2_FLOOR / 2;

  localparam int ADDR_W     = 14;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NODE_ID   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIX     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FIXED_DST = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SENDER    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_VNET_MODE = 3'd7;

  // Traffic patterns
  localparam logic [2:0] PAT_UNIFORM    = 3'd0;
  localparam logic [2:0] PAT_COMPLEMENT = 3'd1;
  localparam logic [2:0] PAT_REVERSE    = 3'd2;
  localparam logic [2:0] PAT_ROTATION   = 3'd3;
  localparam logic [2:0] PAT_NEIGHBOR   = 3'd4;
  localparam logic [2:0] PAT_SHUFFLE    = 3'd5;
  localparam logic [2:0] PAT_TRANSPOSE  = 3'd6;
  localparam logic [2:0] PAT_TORNADO    = 3'd7;

  // Virtual network modes and request kinds
  localparam logic signed [4:0] VNET_RAND_LOW  = -5'sd1;
  localparam logic signed [4:0] VNET_RAND_HIGH = -5'sd2;
  localparam logic [3:0] VNET_DEFAULT = 4'd2;
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_IFETCH = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // Reset values
  localparam logic [2:0] RADIX_LOG2_RESET = 3'd2;

  typedef struct packed {
    logic [2:0]         traffic_pattern;
    logic [7:0]         node_id;
    logic [2:0]         radix_log2;
    logic signed [8:0]  fixed_destination;
    logic signed [8:0]  only_sender;
    logic [15:0]        inject_threshold;
    logic signed [31:0] packet_limit;
    logic signed [4:0]  vnet_mode;
  } cfg_t;

  typedef struct packed {
    logic [15:0] inject_draw;
    logic [7:0]  dest_draw;
    logic [2:0]  vnet_draw;
  } ntg_in_t;

  typedef struct packed {
    logic              send_valid;
    logic [7:0]        destination;
    logic [ADDR_W-1:0] packet_address;
    logic [3:0]        virtual_network;
    logic [1:0]        request_kind;
  } ntg_out_t;

endpackage
`default_nettype wire

// ----- hdl/noc_synthetic_traffic_generator.sv -----
// Synthetic traffic source for one node of a square mesh.
// Input channel (in_valid/in_ready/in_data): one transfer per network tick,
//   carrying the injection, destination and virtual network draws.
// Output channel (out_valid/out_ready/out_data): one result per input
//   transfer, in order; send_valid = 0 means no packet this tick and all
//   other fields read zero.
// Config port (cfg_we/cfg_index/cfg_data): single-cycle register writes; the user
//   must make them while no transfer is in flight, which the block does not enforce.
// Pipeline: an input transfer loads the input register, and the result
//   register then loads from it, which raises out_valid. Throughput: one
//   item per cycle while out_ready is not held low; the destination
//   and decision logic is a single combinational pass between the two
//   registers, and the sent-packet counter is updated in that same pass.
// Stall: while out_ready is low the result register holds; one more item
//   is taken into the input register, then in_ready drops.
// Reset: clears the valid flags of both pipeline stages, the sent-packet
//   counter and all configuration registers to their defaults.
`default_nettype none
module noc_synthetic_traffic_generator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire ntg_pkg::ntg_in_t                in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output ntg_pkg::ntg_out_t                    out_data,
  input  wire logic                            cfg_we,
  input  wire logic [ntg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ntg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ntg_pkg::*;

  cfg_t     cfg;
  ntg_in_t  s1_data;
  logic     s1_valid;
  logic     s1_advance;
  logic     send;
  logic     limit_hit;
  logic     sender_blocked;
  logic [7:0] dest;
  logic [3:0] vnet;
  logic [1:0] kind;
  logic [1:0] vdraw_mod3;
  ntg_out_t res;
  logic [31:0] sent_count;
  logic [31:0] sent_count_next;

  ntg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ntg_dest u_dest (
    .cfg         (cfg),
    .dest_draw   (s1_data.dest_draw),
    .destination (dest)
  );

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_comb begin
    limit_hit      = !cfg.packet_limit[31] && (sent_count >= $unsigned(cfg.packet_limit));
    sender_blocked = !cfg.only_sender[8] && (cfg.only_sender[7:0] != cfg.node_id);
    send = (s1_data.inject_draw < cfg.inject_threshold) && !limit_hit && !sender_blocked;

    case (s1_data.vnet_draw)
      3'd0, 3'd3, 3'd6: vdraw_mod3 = 2'd0;
      3'd1, 3'd4, 3'd7: vdraw_mod3 = 2'd1;
      default:          vdraw_mod3 = 2'd2;
    endcase

    if (cfg.vnet_mode == VNET_RAND_LOW) vnet = 4'(vdraw_mod3);
    else if (cfg.vnet_mode == VNET_RAND_HIGH) vnet = 4'd2 + 4'(s1_data.vnet_draw);
    else if (cfg.vnet_mode[4]) vnet = VNET_DEFAULT;
    else vnet = cfg.vnet_mode[3:0];

    if (vnet == 4'd0) kind = KIND_READ;
    else if (vnet == 4'd1) kind = KIND_IFETCH;
    else kind = KIND_WRITE;

    res = '0;
    if (send) begin
      res.send_valid      = 1'b1;
      res.destination     = dest;
      res.packet_address  = ADDR_W'({{(ADDR_W-8){1'b0}}, dest} << BLOCK_OFFSET_BITS);
      res.virtual_network = vnet;
      res.request_kind    = kind;
    end

    sent_count_next = sent_count;
    if (s1_advance && send && (sent_count != '1)) sent_count_next = sent_count + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      sent_count <= '0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (s1_advance) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      sent_count <= sent_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_data <= in_data;
    if (s1_advance) out_data <= res;
  end

`ifndef SYNTHESIS
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && send && (sent_count != '1)) |=> sent_count == $past(sent_count) + 32'd1)
    else $error("sent counter did not advance on an injected packet");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !(s1_advance && send) |=> $stable(sent_count))
    else $error("sent counter changed without an injected packet");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.send_valid) |->
      (out_data.destination == '0 && out_data.packet_address == '0 &&
       out_data.virtual_network == '0 && out_data.request_kind == '0))
    else $error("result without a packet carries nonzero fields");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled while pipeline has room");
`endif

endmodule
`default_nettype wire

// ----- hdl/ntg_cfg.sv -----
`default_nettype none
module ntg_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ntg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ntg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output ntg_pkg::cfg_t                       cfg
);
  import ntg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.traffic_pattern   <= PAT_UNIFORM;
      cfg.node_id           <= '0;
      cfg.radix_log2        <= RADIX_LOG2_RESET;
      cfg.fixed_destination <= -9'sd1;
      cfg.only_sender       <= -9'sd1;
      cfg.inject_threshold  <= '0;
      cfg.packet_limit      <= -32'sd1;
      cfg.vnet_mode         <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN:   cfg.traffic_pattern   <= cfg_data[2:0];
        REG_NODE_ID:   cfg.node_id           <= cfg_data[7:0];
        REG_RADIX:     cfg.radix_log2        <= cfg_data[2:0];
        REG_FIXED_DST: cfg.fixed_destination <= $signed(cfg_data[8:0]);
        REG_SENDER:    cfg.only_sender       <= $signed(cfg_data[8:0]);
        REG_THRESHOLD: cfg.inject_threshold  <= cfg_data[15:0];
        REG_LIMIT:     cfg.packet_limit      <= $signed(cfg_data[31:0]);
        REG_VNET_MODE: cfg.vnet_mode         <= $signed(cfg_data[4:0]);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ntg_dest.sv -----
`default_nettype none
module ntg_dest (
  input  wire ntg_pkg::cfg_t cfg,
  input  wire logic [7:0]  dest_draw,
  output logic [7:0]       destination
);
  import ntg_pkg::*;

  logic [2:0] r_clamp;
  logic [2:0] r;
  logic [3:0] two_r;
  logic [8:0] nodes;
  logic [7:0] nodes_mask;
  logic [7:0] half_nodes;
  logic [4:0] k;
  logic [3:0] kmask;
  logic [3:0] half_k;
  logic [7:0] id;
  logic [3:0] sx;
  logic [3:0] sy;
  logic [7:0] sy_row;
  logic [7:0] sx_row;
  logic [7:0] id_rev;
  logic [8:0] id_x2;

  // uniform draw reduction, modulo nodes - 1
  logic [3:0] m3_s;
  logic [2:0] m3_t;
  logic [2:0] m3_u;
  logic [1:0] m3;
  logic [4:0] m15_t;
  logic [4:0] m15_u;
  logic [3:0] m15;
  logic [6:0] m63_t;
  logic [5:0] m63;
  logic [7:0] m255;
  logic [7:0] umod;

  logic [7:0] pat_dest;

  always_comb begin
    if (cfg.radix_log2 == 3'd0) r_clamp = 3'd1;
    else if (cfg.radix_log2 > 3'd4) r_clamp = 3'd4;
    else r_clamp = cfg.radix_log2;
    r = (r_clamp > 3'(RADIX_LOG2_CAP)) ? 3'(RADIX_LOG2_CAP) : r_clamp;

    two_r      = {r, 1'b0};
    nodes      = 9'd1 << two_r;
    nodes_mask = 8'(nodes - 9'd1);
    half_nodes = nodes[8:1];
    k          = 5'd1 << r;
    kmask      = 4'(k - 5'd1);
    half_k     = k[4:1];

    id     = cfg.node_id & nodes_mask;
    sx     = id[3:0] & kmask;
    sy     = 4'(id >> r);
    sy_row = 8'({4'd0, sy} << r);
    sx_row = 8'({4'd0, sx} << r);
    for (int i = 0; i < 8; i++) id_rev[i] = id[7-i];
    id_x2 = {id, 1'b0};

    m3_s = 4'(id_x2[0]) + 4'(dest_draw[1:0]) + 4'(dest_draw[3:2])
         + 4'(dest_draw[5:4]) + 4'(dest_draw[7:6]);
    m3_t = 3'(m3_s[1:0]) + 3'(m3_s[3:2]);
    m3_u = (m3_t >= 3'd3) ? m3_t - 3'd3 : m3_t;
    m3   = 2'((m3_u >= 3'd3) ? m3_u - 3'd3 : m3_u);

    m15_t = 5'(dest_draw[3:0]) + 5'(dest_draw[7:4]);
    m15_u = (m15_t >= 5'd15) ? m15_t - 5'd15 : m15_t;
    m15   = 4'((m15_u >= 5'd15) ? m15_u - 5'd15 : m15_u);

    m63_t = 7'(dest_draw[5:0]) + 7'(dest_draw[7:6]);
    m63   = 6'((m63_t >= 7'd63) ? m63_t - 7'd63 : m63_t);

    m255 = (dest_draw == 8'hFF) ? 8'd0 : dest_draw;

    case (r)
      3'd1:    umod = 8'(m3);
      3'd2:    umod = 8'(m15);
      3'd3:    umod = 8'(m63);
      default: umod = m255;
    endcase

    case (cfg.traffic_pattern)
      PAT_UNIFORM:    pat_dest = (umod >= id) ? umod + 8'd1 : umod;
      PAT_COMPLEMENT: pat_dest = 8'({4'd0, ~sy & kmask} << r) | 8'(~sx & kmask);
      PAT_REVERSE:    pat_dest = id_rev >> (4'd8 - two_r);
      PAT_ROTATION:   pat_dest = id[0] ? (id >> 1) + half_nodes : (id >> 1);
      PAT_NEIGHBOR:   pat_dest = sy_row | 8'((sx + 4'd1) & kmask);
      PAT_SHUFFLE:    pat_dest = (id < half_nodes) ? id_x2[7:0]
                                 : 8'(id_x2 - nodes + 9'd1);
      PAT_TRANSPOSE:  pat_dest = sx_row | 8'(sy);
      PAT_TORNADO:    pat_dest = sy_row | 8'((sx + half_k + kmask) & kmask);
      default:        pat_dest = '0;
    endcase

    destination = cfg.fixed_destination[8] ? pat_dest : cfg.fixed_destination[7:0];
  end

endmodule
`default_nettype wire

// ----- tb/sv/tb_noc_synthetic_traffic_generator.sv -----
`timescale 1ns / 100ps
module tb_noc_synthetic_traffic_generator;
  import ntg_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_ITEMS = 1350;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  ntg_in_t                in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  ntg_out_t               out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  noc_synthetic_traffic_generator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block: configuration and sent-packet counter
  cfg_t        model_cfg;
  logic [31:0] model_sent = '0;

  ntg_in_t  pending_draws[$];
  ntg_out_t expected_packets[$];
  ntg_out_t want;
  int       queued_count = 0;
  int       accepted_count = 0;
  int       results_checked = 0;
  int       mismatch_count = 0;
  int       cycle_count = 0;
  logic     in_fire = 1'b0;

  bit       sender_idle_on = 1'b0;
  bit       receiver_idle_on = 1'b0;
  int       hold_events = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  int       stall_left = 0;
  int       send_gap = 0;

  int         dir_radix [8] = '{0, 1, 2, 3, 4, 5, 7, 4};
  logic [4:0] dir_vnet  [8] = '{5'h1F, 5'h1E, 5'h1D, 5'h10, 5'd10, 5'd15, 5'd0, 5'd1};

  function automatic ntg_out_t compute_packet(input ntg_in_t t);
    ntg_out_t res;
    bit       send;
    longint   sent_l;
    longint   limit_l;
    int       r, k, nodes, id, sx, sy, d, i, addr, vnet, vm;
    res = '0;
    send = t.inject_draw < model_cfg.inject_threshold;
    sent_l = model_sent;
    limit_l = $signed(model_cfg.packet_limit);
    if (!model_cfg.packet_limit[31] && sent_l >= limit_l) send = 1'b0;
    if (!model_cfg.only_sender[8] &&
        int'(model_cfg.node_id) != int'(model_cfg.only_sender[7:0])) send = 1'b0;
    if (!send) return res;

    if (!model_cfg.fixed_destination[8]) begin
      d = model_cfg.fixed_destination[7:0];
    end else begin
      r = model_cfg.radix_log2;
      if (r < 1) r = 1;
      if (r > 4) r = 4;
      while (r > 1 && (1 << (2 * r)) > MAX_NODES) r--;
      k = 1 << r;
      nodes = k * k;
      id = model_cfg.node_id & (nodes - 1);
      sx = id & (k - 1);
      sy = id >> r;
      case (model_cfg.traffic_pattern)
        PAT_UNIFORM: begin
          // skip over own index so a node never targets itself
          d = int'(t.dest_draw) % (nodes - 1);
          if (d >= id) d++;
        end
        PAT_COMPLEMENT: d = (k - 1 - sy) * k + (k - 1 - sx);
        PAT_REVERSE: begin
          d = 0;
          for (i = 0; i < 2 * r; i++) d = (d << 1) | ((id >> i) & 1);
        end
        PAT_ROTATION:  d = (id & 1) ? (id >> 1) + nodes / 2 : (id >> 1);
        PAT_NEIGHBOR:  d = sy * k + ((sx + 1) & (k - 1));
        PAT_SHUFFLE:   d = (id < nodes / 2) ? id * 2 : id * 2 - nodes + 1;
        PAT_TRANSPOSE: d = sx * k + sy;
        default:       d = sy * k + ((sx + k / 2 + k - 1) & (k - 1));
      endcase
    end
    d = d & 8'hFF;

    vm = $signed(model_cfg.vnet_mode);
    if (model_cfg.vnet_mode == VNET_RAND_LOW)       vnet = int'(t.vnet_draw) % 3;
    else if (model_cfg.vnet_mode == VNET_RAND_HIGH) vnet = 2 + int'(t.vnet_draw);
    else if (vm < 0)                                vnet = VNET_DEFAULT;
    else                                            vnet = vm & 15;

    if (model_sent != '1) model_sent++;

    addr = d << BLOCK_OFFSET_BITS;
    res.send_valid      = 1'b1;
    res.destination     = d[7:0];
    res.packet_address  = addr[ADDR_W-1:0];
    res.virtual_network = vnet[3:0];
    res.request_kind    = (vnet == 0) ? KIND_READ : (vnet == 1) ? KIND_IFETCH : KIND_WRITE;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH @%0t result %0d: %s", $time, results_checked, what);
  endtask

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 88) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Sender: holds valid and payload until the transfer completes
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_draws.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending_draws.pop_front();
        if (sender_idle_on) send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus long hold-offs on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_events) begin
      hold_seen = hold_events;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (receiver_idle_on) stall_left = pick_gap();
    end
  end

  // Monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_packets.size() == 0) begin
          report_mismatch("result with no packet decision pending");
        end else begin
          want = expected_packets.pop_front();
          if (out_data.send_valid !== want.send_valid)
            report_mismatch($sformatf("send_valid got %0d want %0d",
                                      out_data.send_valid, want.send_valid));
          if (out_data.destination !== want.destination)
            report_mismatch($sformatf("destination got %0d want %0d",
                                      out_data.destination, want.destination));
          if (out_data.packet_address !== want.packet_address)
            report_mismatch($sformatf("packet_address got %0h want %0h",
                                      out_data.packet_address, want.packet_address));
          if (out_data.virtual_network !== want.virtual_network)
            report_mismatch($sformatf("virtual_network got %0d want %0d",
                                      out_data.virtual_network, want.virtual_network));
          if (out_data.request_kind !== want.request_kind)
            report_mismatch($sformatf("request_kind got %0d want %0d",
                                      out_data.request_kind, want.request_kind));
        end
        results_checked++;
      end
      if (in_valid && in_ready) begin
        expected_packets = {expected_packets, compute_packet(in_data)};
        accepted_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("noc_synthetic_traffic_generator regression: fail");
      $finish;
    end
  end

  task automatic wait_idle();
    while (accepted_count != queued_count || expected_packets.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_PATTERN:   model_cfg.traffic_pattern   = data[2:0];
      REG_NODE_ID:   model_cfg.node_id           = data[7:0];
      REG_RADIX:     model_cfg.radix_log2        = data[2:0];
      REG_FIXED_DST: model_cfg.fixed_destination = data[8:0];
      REG_SENDER:    model_cfg.only_sender       = data[8:0];
      REG_THRESHOLD: model_cfg.inject_threshold  = data[15:0];
      REG_LIMIT:     model_cfg.packet_limit      = data;
      default:       model_cfg.vnet_mode         = data[4:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits for the block to drain, then rewrites every register
  task automatic set_config(input cfg_t c);
    wait_idle();
    write_reg(REG_PATTERN, 32'(c.traffic_pattern));
    write_reg(REG_NODE_ID, 32'(c.node_id));
    write_reg(REG_RADIX, 32'(c.radix_log2));
    write_reg(REG_FIXED_DST, {{23{c.fixed_destination[8]}}, c.fixed_destination});
    write_reg(REG_SENDER, {{23{c.only_sender[8]}}, c.only_sender});
    write_reg(REG_THRESHOLD, 32'(c.inject_threshold));
    write_reg(REG_LIMIT, c.packet_limit);
    write_reg(REG_VNET_MODE, {{27{c.vnet_mode[4]}}, c.vnet_mode});
  endtask

  task automatic queue_tick(input logic [15:0] inj, input logic [7:0] dst, input logic [2:0] vn);
    ntg_in_t t;
    t.inject_draw = inj;
    t.dest_draw = dst;
    t.vnet_draw = vn;
    pending_draws = {pending_draws, t};
    queued_count++;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    int   sel;
    c.traffic_pattern = 3'($urandom_range(0, 7));
    c.radix_log2 = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) :
                                                  3'($urandom_range(1, 4));
    c.node_id = 8'($urandom_range(0, 255));
    c.fixed_destination = ($urandom_range(0, 99) < 15) ? 9'($urandom_range(0, 255)) :
                                                          9'($urandom_range(256, 511));
    sel = $urandom_range(0, 99);
    if (sel < 70)      c.only_sender = 9'($urandom_range(256, 511));
    else if (sel < 90) c.only_sender = {1'b0, c.node_id};
    else               c.only_sender = 9'($urandom_range(0, 255));
    sel = $urandom_range(0, 99);
    if (sel < 8)       c.inject_threshold = 16'd0;
    else if (sel < 18) c.inject_threshold = 16'hFFFF;
    else if (sel < 30) c.inject_threshold = 16'($urandom_range(0, 65535));
    else               c.inject_threshold = 16'($urandom_range(32768, 65535));
    sel = $urandom_range(0, 99);
    if (sel < 65)      c.packet_limit = 32'h8000_0000 | $urandom;
    else if (sel < 90) c.packet_limit = model_sent + 32'($urandom_range(0, 30));
    else               c.packet_limit = $urandom >> 1;
    c.vnet_mode = ($urandom_range(0, 99) < 40) ? (($urandom_range(0, 1) == 0) ? VNET_RAND_LOW :
                                                                                VNET_RAND_HIGH) :
                                                 5'($urandom_range(0, 31));
    return c;
  endfunction

  initial begin
    cfg_t c;
    int   p;
    int   n;
    int   random_items;
    int   phase;

    model_cfg.traffic_pattern   = PAT_UNIFORM;
    model_cfg.node_id           = 8'd0;
    model_cfg.radix_log2        = RADIX_LOG2_RESET;
    model_cfg.fixed_destination = -9'sd1;
    model_cfg.only_sender       = -9'sd1;
    model_cfg.inject_threshold  = 16'd0;
    model_cfg.packet_limit      = -32'sd1;
    model_cfg.vnet_mode         = 5'd0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Reset state: threshold zero, so nothing is injected
    queue_tick(16'h0000, 8'h00, 3'd0);
    queue_tick(16'hFFFF, 8'hFF, 3'd7);

    // Each pattern once, with out-of-range radix, nodes beyond the mesh and odd vnet modes
    c = model_cfg;
    c.inject_threshold = 16'hFFFF;
    for (p = 0; p < 8; p++) begin
      c.traffic_pattern = 3'(p);
      c.node_id = 8'(p * 37);
      c.radix_log2 = 3'(dir_radix[p]);
      c.vnet_mode = dir_vnet[p];
      set_config(c);
      queue_tick(16'h0000, (p % 2) ? 8'h00 : 8'hFF, 3'd7);
    end

    // Fixed destination at the top, vnet random high
    c.fixed_destination = 9'sd255;
    c.vnet_mode = VNET_RAND_HIGH;
    set_config(c);
    queue_tick(16'h0000, 8'h12, 3'd0);
    queue_tick(16'hFFFE, 8'h34, 3'd7);

    // Sender filter matching this node, threshold of one
    c.fixed_destination = 9'sd0;
    c.node_id = 8'd3;
    c.only_sender = 9'sd3;
    c.inject_threshold = 16'd1;
    c.vnet_mode = 5'd0;
    set_config(c);
    queue_tick(16'h0000, 8'h00, 3'd1);
    queue_tick(16'h0001, 8'h00, 3'd1);

    c.only_sender = 9'sd255;
    c.inject_threshold = 16'hFFFF;
    set_config(c);
    queue_tick(16'h0000, 8'h00, 3'd2);
    c.only_sender = 9'h100;
    c.fixed_destination = 9'h100;
    set_config(c);
    queue_tick(16'h0000, 8'h40, 3'd3);

    // Packet limit reached after two more
    wait_idle();
    c.packet_limit = model_sent + 32'd2;
    set_config(c);
    queue_tick(16'h0000, 8'h01, 3'd4);
    queue_tick(16'h0000, 8'h02, 3'd5);
    queue_tick(16'h0000, 8'h03, 3'd6);

    c.packet_limit = 32'd0;
    set_config(c);
    queue_tick(16'h0000, 8'h05, 3'd0);
    c.packet_limit = 32'h7FFF_FFFF;
    set_config(c);
    queue_tick(16'h0000, 8'h06, 3'd1);
    c.packet_limit = 32'h8000_0000;
    set_config(c);
    queue_tick(16'h0000, 8'h07, 3'd2);

    // Uniform draw on both sides of the node's own index
    c.traffic_pattern = PAT_UNIFORM;
    c.radix_log2 = 3'd1;
    c.node_id = 8'd2;
    c.vnet_mode = VNET_RAND_LOW;
    set_config(c);
    queue_tick(16'h0000, 8'h01, 3'd5);
    queue_tick(16'h0000, 8'h02, 3'd7);

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      set_config(random_cfg());
      sender_idle_on = ($urandom_range(0, 3) != 0);
      receiver_idle_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(20, 110);
      for (p = 0; p < n; p++)
        queue_tick(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                   3'($urandom_range(0, 7)));
      // long receiver hold-off while the sender keeps offering
      if (phase == 1 || phase == 9) hold_events++;
      random_items += n;
      phase++;
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("noc_synthetic_traffic_generator regression: pass");
    end else begin
      $display("noc_synthetic_traffic_generator regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ntg_pkg.sv
hdl/ntg_cfg.sv
hdl/ntg_dest.sv
hdl/noc_synthetic_traffic_generator.sv
tb/sv/tb_noc_synthetic_traffic_generator.sv
